// ===== hw/rtl/route_split_shortest_path_defines.svh =====
// Assertion macros shared by the route split RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ROUTE_SPLIT_SHORTEST_PATH_DEFINES_SVH
`define ROUTE_SPLIT_SHORTEST_PATH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSS_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("route split check failed");

// The consequent must hold in the cycle after the antecedent.
`define RSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("route split check failed");

`endif

// ===== hw/rtl/rss_pkg.sv =====
// Shared constants, types and saturating arithmetic for the route split block.
// No dependencies; rss_relax and the top level refer to it by scoped names.
package rss_pkg;

    // Cost format: unsigned Q40.8, saturating at all ones.
    localparam int COST_W    = 48;
    localparam int FRAC_BITS = 8;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // Field and register widths.
    localparam int DEMAND_W   = 16;
    localparam int CAP_W      = 22;
    localparam int PEN_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY  = 2'd1;

    // Configuration reset values.
    localparam logic [CAP_W-1:0] CAP_RESET = {CAP_W{1'b1}};
    localparam logic [PEN_W-1:0] PEN_RESET = 16'd256;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_CLIENTS = 64;
    localparam int DEF_DIST_BITS   = 16;

    // Control that travels with one pair through the relaxation pipeline.
    typedef struct packed {
        logic valid;   // a pair is issued this cycle
        logic first;   // first client of the trip (j == i + 1)
        logic init;    // start node is the depot (i == 0): take the first candidate
    } relax_ctrl_t;

    // Saturating add of two costs.
    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
        logic [COST_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/rss_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/rss_relax.sv =====
// Relaxation unit: evaluates one (start node, end node) pair per cycle in a five-stage pipeline.
// Depends on rss_pkg; its operands come from the registered read ports of the top-level RAMs.
module rss_relax #(
    parameter int NODE_W    = 7,
    parameter int LOAD_W    = 22,
    parameter int DIST_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rss_pkg::relax_ctrl_t           issue,
    input  logic [NODE_W-1:0]              issue_node,
    input  logic [rss_pkg::DEMAND_W-1:0]   demand_rd,
    input  logic [DIST_BITS-1:0]           depot_rd,
    input  logic [DIST_BITS-1:0]           next_rd,
    input  logic [rss_pkg::COST_W-1:0]     best_node_rd,
    input  logic [rss_pkg::COST_W-1:0]     best_start,
    input  logic [rss_pkg::CAP_W-1:0]      capacity,
    input  logic [rss_pkg::PEN_W-1:0]      penalty,
    output logic                           wr_en,
    output logic [NODE_W-1:0]              wr_node,
    output logic [rss_pkg::COST_W-1:0]     wr_cost,
    output logic                           pipe_busy
);

    localparam int COST_W = rss_pkg::COST_W;
    localparam int CAP_W  = rss_pkg::CAP_W;
    localparam int PROD_W = rss_pkg::PEN_W + LOAD_W;
    localparam int CMP_W  = (LOAD_W > CAP_W) ? LOAD_W : CAP_W;

    // Stage 1: pair control, aligned with the RAM read data.
    rss_pkg::relax_ctrl_t s1_ctrl_reg;
    logic [NODE_W-1:0]    s1_node_reg;

    // Stage 2: running load and distance of the trip.
    logic                 s2_valid_reg;
    logic                 s2_init_reg;
    logic [NODE_W-1:0]    s2_node_reg;
    logic [LOAD_W-1:0]    load_reg;
    logic [COST_W-1:0]    dist_reg;
    logic [DIST_BITS-1:0] s2_depot_reg;
    logic [COST_W-1:0]    s2_best_reg;

    // Stage 3: excess load and trip distance back to the depot.
    logic                 s3_valid_reg;
    logic                 s3_init_reg;
    logic [NODE_W-1:0]    s3_node_reg;
    logic [LOAD_W-1:0]    excess_reg;
    logic [COST_W-1:0]    s3_tpre_reg;
    logic [COST_W-1:0]    s3_best_reg;

    // Stage 4: penalty product.
    logic                 s4_valid_reg;
    logic                 s4_init_reg;
    logic [NODE_W-1:0]    s4_node_reg;
    logic [PROD_W-1:0]    pen_reg;
    logic [COST_W-1:0]    s4_tpre_reg;
    logic [COST_W-1:0]    s4_best_reg;

    // Stage 5: trip cost, compared against the stored best.
    logic                 s5_valid_reg;
    logic                 s5_init_reg;
    logic [NODE_W-1:0]    s5_node_reg;
    logic [COST_W-1:0]    trip_reg;
    logic [COST_W-1:0]    s5_best_reg;

    logic [LOAD_W-1:0]    load_next;
    logic [DIST_BITS-1:0] step_dist;
    logic [COST_W-1:0]    dist_next;
    logic                 overloaded;
    logic [LOAD_W-1:0]    excess_next;
    logic [COST_W-1:0]    tpre_next;
    logic [PROD_W-1:0]    pen_next;
    logic [COST_W-1:0]    trip_next;
    logic [COST_W-1:0]    cand;

    // Running load and distance restart on the first client of a trip.
    always_comb
    begin
        load_next = (s1_ctrl_reg.first ? '0 : load_reg) + LOAD_W'(demand_rd);
        step_dist = s1_ctrl_reg.first ? depot_rd : next_rd;
        dist_next = rss_pkg::sat_add(s1_ctrl_reg.first ? '0 : dist_reg,
                                     COST_W'(step_dist) << rss_pkg::FRAC_BITS);
    end

    // Excess over capacity and the return leg to the depot.
    always_comb
    begin
        overloaded  = CMP_W'(load_reg) > CMP_W'(capacity);
        excess_next = overloaded ? (load_reg - LOAD_W'(capacity)) : '0;
        tpre_next   = rss_pkg::sat_add(dist_reg,
                                       COST_W'(s2_depot_reg) << rss_pkg::FRAC_BITS);
    end

    // Penalty product; it stays below the cost limit, so it needs no clamp.
    assign pen_next  = PROD_W'(penalty) * PROD_W'(excess_reg);
    assign trip_next = rss_pkg::sat_add(s4_tpre_reg, COST_W'(pen_reg));

    // Candidate cost; updates the end node from the depot, else on strict improvement only.
    assign cand    = rss_pkg::sat_add(best_start, trip_reg);
    assign wr_en   = s5_valid_reg && (s5_init_reg || (cand < s5_best_reg));
    assign wr_node = s5_node_reg;
    assign wr_cost = cand;

    assign pipe_busy = s1_ctrl_reg.valid || s2_valid_reg || s3_valid_reg ||
                       s4_valid_reg || s5_valid_reg;

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg  <= '0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_ctrl_reg  <= issue;
            s2_valid_reg <= s1_ctrl_reg.valid;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        s1_node_reg <= issue_node;

        if (s1_ctrl_reg.valid)
        begin
            load_reg <= load_next;
            dist_reg <= dist_next;
        end
        s2_init_reg  <= s1_ctrl_reg.init;
        s2_node_reg  <= s1_node_reg;
        s2_depot_reg <= depot_rd;
        s2_best_reg  <= best_node_rd;

        s3_init_reg <= s2_init_reg;
        s3_node_reg <= s2_node_reg;
        excess_reg  <= excess_next;
        s3_tpre_reg <= tpre_next;
        s3_best_reg <= s2_best_reg;

        s4_init_reg <= s3_init_reg;
        s4_node_reg <= s3_node_reg;
        pen_reg     <= pen_next;
        s4_tpre_reg <= s3_tpre_reg;
        s4_best_reg <= s3_best_reg;

        s5_init_reg <= s4_init_reg;
        s5_node_reg <= s4_node_reg;
        trip_reg    <= trip_next;
        s5_best_reg <= s4_best_reg;
    end

endmodule

// ===== hw/rtl/route_split_shortest_path.sv =====
// Route split by shortest path: loads a giant tour, then splits it into routes at least cost.
// Top level; depends on rss_pkg, rss_ram, rss_relax and route_split_shortest_path_defines.svh.
//
// Clients arrive one transaction per cycle while busy is low. The client marked last, or
// the one that fills MAX_CLIENTS entries, starts a run with busy high. During a run the
// relaxation unit evaluates one trip per cycle of each sweep, and each start node adds a
// cost fetch and a drain of the five-stage pipeline. Tracing back the best split then
// reads the predecessor RAM once per route, and the results follow at one per cycle,
// in tour order, each marked by result_valid for exactly one cycle. The receiver cannot
// stall: it must take each result in the cycle it appears. route_count, total_cost and
// saturated are the same on every result of a run. Configuration writes are always ready.
`include "route_split_shortest_path_defines.svh"

module route_split_shortest_path #(
    parameter int MAX_CLIENTS = rss_pkg::DEF_MAX_CLIENTS,
    parameter int DIST_BITS   = rss_pkg::DEF_DIST_BITS,
    localparam int AW     = $clog2(MAX_CLIENTS),
    localparam int NODE_W = $clog2(MAX_CLIENTS + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [rss_pkg::DEMAND_W-1:0]    demand,
    input  logic [DIST_BITS-1:0]            depot_distance,
    input  logic [DIST_BITS-1:0]            next_distance,
    input  logic                            last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rss_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            result_valid,
    output logic [NODE_W-1:0]               route_first_client,
    output logic [AW-1:0]                   route_number,
    output logic [NODE_W-1:0]               route_count,
    output logic [rss_pkg::COST_W-1:0]      total_cost,
    output logic                            saturated,
    output logic                            last_route
);

    localparam int COST_W   = rss_pkg::COST_W;
    localparam int DEMAND_W = rss_pkg::DEMAND_W;
    localparam int LOAD_W   = DEMAND_W + AW;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE        = 3'd0;
    localparam logic [2:0] ST_OUTER_RD    = 3'd1;
    localparam logic [2:0] ST_OUTER_WAIT  = 3'd2;
    localparam logic [2:0] ST_INNER       = 3'd3;
    localparam logic [2:0] ST_DRAIN       = 3'd4;
    localparam logic [2:0] ST_TRACE_RD    = 3'd5;
    localparam logic [2:0] ST_TRACE_WAIT  = 3'd6;
    localparam logic [2:0] ST_EMIT        = 3'd7;

    logic [2:0]                  state_reg, state_next;
    logic [NODE_W-1:0]           client_count_reg, client_count_next;
    logic [NODE_W-1:0]           n_reg, n_next;
    logic [NODE_W-1:0]           i_reg, i_next;
    logic [NODE_W-1:0]           j_reg, j_next;
    logic [NODE_W-1:0]           node_reg, node_next;
    logic [NODE_W-1:0]           walk_reg, walk_next;
    logic [NODE_W-1:0]           count_reg, count_next;
    logic [AW-1:0]               k_reg, k_next;
    logic [COST_W-1:0]           best_start_reg, best_start_next;
    logic [COST_W-1:0]           total_reg, total_next;
    logic [rss_pkg::CAP_W-1:0]   capacity_reg;
    logic [rss_pkg::PEN_W-1:0]   penalty_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [AW-1:0]               out_number_reg, out_number_next;
    logic                        out_last_reg, out_last_next;

    logic                        in_accept;
    logic                        tour_ends;
    logic                        k_is_last;
    logic [NODE_W-1:0]           emit_index;

    // RAM ports.
    logic [AW-1:0]               store_wr_addr;
    logic [AW-1:0]               cur_rd_addr;
    logic [AW-1:0]               prev_rd_addr;
    logic [DEMAND_W-1:0]         demand_rd;
    logic [DIST_BITS-1:0]        depot_rd;
    logic [DIST_BITS-1:0]        next_rd;
    logic [NODE_W-1:0]           best_rd_addr;
    logic [COST_W-1:0]           best_rd;
    logic [NODE_W-1:0]           pred_rd;
    logic                        starts_wr_en;
    logic [AW-1:0]               starts_wr_addr;
    logic [NODE_W-1:0]           starts_wr_data;
    logic [AW-1:0]               starts_rd_addr;
    logic [NODE_W-1:0]           starts_rd;

    // Relaxation unit interface.
    rss_pkg::relax_ctrl_t        relax_issue;
    logic                        relax_wr_en;
    logic [NODE_W-1:0]           relax_wr_node;
    logic [COST_W-1:0]           relax_wr_cost;
    logic                        relax_busy;

    assign busy      = (state_reg != ST_IDLE);
    assign in_accept = start && !busy;
    assign tour_ends = last || (client_count_reg == NODE_W'(MAX_CLIENTS - 1));
    assign cfg_ready = 1'b1;

    // Client stores, written while loading and read along the trip being relaxed.
    assign store_wr_addr = client_count_reg[AW-1:0];
    assign cur_rd_addr   = AW'(j_reg - 1'b1);
    assign prev_rd_addr  = AW'(j_reg - NODE_W'(2));

    rss_ram #(.WIDTH(DEMAND_W), .DEPTH(MAX_CLIENTS)) u_demand_ram (
        .clk     (clk),
        .wr_en   (in_accept),
        .wr_addr (store_wr_addr),
        .wr_data (demand),
        .rd_addr (cur_rd_addr),
        .rd_data (demand_rd)
    );

    rss_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_CLIENTS)) u_depot_ram (
        .clk     (clk),
        .wr_en   (in_accept),
        .wr_addr (store_wr_addr),
        .wr_data (depot_distance),
        .rd_addr (cur_rd_addr),
        .rd_data (depot_rd)
    );

    rss_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_CLIENTS)) u_next_ram (
        .clk     (clk),
        .wr_en   (in_accept),
        .wr_addr (store_wr_addr),
        .wr_data (next_distance),
        .rd_addr (prev_rd_addr),
        .rd_data (next_rd)
    );

    // Best cost and predecessor per node; one best-cost read address serves each phase of the run.
    always_comb
    begin
        case (state_reg)
            ST_OUTER_RD: best_rd_addr = i_reg;
            ST_INNER:    best_rd_addr = j_reg;
            default:     best_rd_addr = n_reg;
        endcase
    end

    rss_ram #(.WIDTH(COST_W), .DEPTH(MAX_CLIENTS + 1)) u_best_ram (
        .clk     (clk),
        .wr_en   (relax_wr_en),
        .wr_addr (relax_wr_node),
        .wr_data (relax_wr_cost),
        .rd_addr (best_rd_addr),
        .rd_data (best_rd)
    );

    rss_ram #(.WIDTH(NODE_W), .DEPTH(MAX_CLIENTS + 1)) u_pred_ram (
        .clk     (clk),
        .wr_en   (relax_wr_en),
        .wr_addr (relax_wr_node),
        .wr_data (i_reg),
        .rd_addr (node_reg),
        .rd_data (pred_rd)
    );

    // Route starts, written last route first during the traceback and read in tour order.
    assign starts_wr_en   = (state_reg == ST_TRACE_WAIT);
    assign starts_wr_addr = walk_reg[AW-1:0];
    assign starts_wr_data = pred_rd + 1'b1;
    assign emit_index     = count_reg - NODE_W'(k_reg) - 1'b1;
    assign starts_rd_addr = emit_index[AW-1:0];

    rss_ram #(.WIDTH(NODE_W), .DEPTH(MAX_CLIENTS)) u_starts_ram (
        .clk     (clk),
        .wr_en   (starts_wr_en),
        .wr_addr (starts_wr_addr),
        .wr_data (starts_wr_data),
        .rd_addr (starts_rd_addr),
        .rd_data (starts_rd)
    );

    // One pair is issued per cycle of the inner sweep.
    always_comb
    begin
        relax_issue.valid = (state_reg == ST_INNER);
        relax_issue.first = (j_reg == i_reg + 1'b1);
        relax_issue.init  = (i_reg == '0);
    end

    rss_relax #(
        .NODE_W    (NODE_W),
        .LOAD_W    (LOAD_W),
        .DIST_BITS (DIST_BITS)
    ) u_relax (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue        (relax_issue),
        .issue_node   (j_reg),
        .demand_rd    (demand_rd),
        .depot_rd     (depot_rd),
        .next_rd      (next_rd),
        .best_node_rd (best_rd),
        .best_start   (best_start_reg),
        .capacity     (capacity_reg),
        .penalty      (penalty_reg),
        .wr_en        (relax_wr_en),
        .wr_node      (relax_wr_node),
        .wr_cost      (relax_wr_cost),
        .pipe_busy    (relax_busy)
    );

    assign k_is_last = (NODE_W'(k_reg) == count_reg - 1'b1);

    // Sequencer: load, relax every start node, trace back, then emit the routes.
    always_comb
    begin
        state_next        = state_reg;
        client_count_next = client_count_reg;
        n_next            = n_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        node_next         = node_reg;
        walk_next         = walk_reg;
        count_next        = count_reg;
        k_next            = k_reg;
        best_start_next   = best_start_reg;
        total_next        = total_reg;
        out_valid_next    = 1'b0;
        out_number_next   = out_number_reg;
        out_last_next     = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (tour_ends)
                    begin
                        n_next            = client_count_reg + 1'b1;
                        client_count_next = '0;
                        i_next            = '0;
                        state_next        = ST_OUTER_RD;
                    end
                    else
                    begin
                        client_count_next = client_count_reg + 1'b1;
                    end
                end
            end
            ST_OUTER_RD:
            begin
                state_next = ST_OUTER_WAIT;
            end
            ST_OUTER_WAIT:
            begin
                // The depot itself costs nothing and is never stored.
                best_start_next = (i_reg == '0) ? '0 : best_rd;
                j_next          = i_reg + 1'b1;
                state_next      = ST_INNER;
            end
            ST_INNER:
            begin
                if (j_reg == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // The next start node reads a cost that this sweep may still be writing.
                if (!relax_busy)
                begin
                    i_next = i_reg + 1'b1;
                    if (i_reg + 1'b1 == n_reg)
                    begin
                        node_next  = n_reg;
                        walk_next  = '0;
                        state_next = ST_TRACE_RD;
                    end
                    else
                    begin
                        state_next = ST_OUTER_RD;
                    end
                end
            end
            ST_TRACE_RD:
            begin
                state_next = ST_TRACE_WAIT;
            end
            ST_TRACE_WAIT:
            begin
                walk_next = walk_reg + 1'b1;
                node_next = pred_rd;
                if (pred_rd == '0)
                begin
                    count_next = walk_reg + 1'b1;
                    total_next = best_rd;
                    k_next     = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_TRACE_RD;
                end
            end
            ST_EMIT:
            begin
                out_valid_next  = 1'b1;
                out_number_next = k_reg;
                out_last_next   = k_is_last;
                if (k_is_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            client_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            client_count_reg <= client_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Configuration registers, written by a transaction on the configuration channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= rss_pkg::CAP_RESET;
            penalty_reg  <= rss_pkg::PEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rss_pkg::CFG_CAPACITY: capacity_reg <= cfg_data[rss_pkg::CAP_W-1:0];
                rss_pkg::CFG_PENALTY:  penalty_reg  <= cfg_data[rss_pkg::PEN_W-1:0];
                default:               ;
            endcase
        end
    end

    // Counters and datapath registers of the run.
    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        node_reg       <= node_next;
        walk_reg       <= walk_next;
        count_reg      <= count_next;
        k_reg          <= k_next;
        best_start_reg <= best_start_next;
        total_reg      <= total_next;
        out_number_reg <= out_number_next;
        out_last_reg   <= out_last_next;
    end

    // Result ports.
    assign result_valid       = out_valid_reg;
    assign route_first_client = starts_rd;
    assign route_number       = out_number_reg;
    assign route_count        = count_reg;
    assign total_cost         = total_reg;
    assign saturated          = (total_reg == rss_pkg::COST_MAX);
    assign last_route         = out_last_reg;

    // Checks on the sequencer and the result stream.
    `RSS_ASSERT_IMPLIES(a_result_after_emit, result_valid, $past(state_reg) == ST_EMIT)
    `RSS_ASSERT_IMPLIES(a_cost_write_in_sweep, relax_wr_en, state_reg == ST_INNER || state_reg == ST_DRAIN)
    `RSS_ASSERT_IMPLIES(a_inner_node_range, state_reg == ST_INNER, j_reg > i_reg && j_reg <= n_reg)
    `RSS_ASSERT_IMPLIES(a_last_route_number, result_valid && last_route, NODE_W'(route_number) == route_count - 1'b1)
    `RSS_ASSERT_NEXT(a_trace_stays_below, state_reg == ST_TRACE_WAIT, node_reg < $past(node_reg))

endmodule
